// ----- hw/rtl/sidt_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter.
package sidt_pkg;

  localparam int unsigned DIGIT_W = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_e;

endpackage

// ----- hw/rtl/sidt_dabble.sv -----
// One shift-and-add-3 step of the binary to BCD conversion over all digit lanes.
module sidt_dabble #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*sidt_pkg::DIGIT_W-1:0] bcd_i,
  input  logic                                    bit_i,
  output logic [NUM_DIGITS*sidt_pkg::DIGIT_W-1:0] bcd_o
);

  localparam int unsigned BCD_W = NUM_DIGITS * sidt_pkg::DIGIT_W;

  logic [BCD_W-1:0] adj;

  // A digit of five or more becomes ten or more after the shift, so it is
  // corrected by three beforehand to carry into the next lane.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i[i*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] >= 4'd5) begin
        adj[i*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] =
            bcd_i[i*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] + 4'd3;
      end else begin
        adj[i*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W] =
            bcd_i[i*sidt_pkg::DIGIT_W +: sidt_pkg::DIGIT_W];
      end
    end
  end

  assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
// Top level: converts a signed integer into its decimal ASCII characters.
//
// Input channel: value_i with in_valid_i / in_stall_o. A transfer happens at a
// clock edge where in_valid_i is high and in_stall_o is low. The block takes
// one number at a time and stalls the input until the last character of that
// number has been loaded into the output register.
// Output channel: char_code_o and last_o with out_valid_o / out_stall_i, one
// character per transfer, most significant first: an optional minus sign,
// then the digits without leading zeros. last_o marks the final character.
// The magnitude goes through a shift-and-add-3 unit one bit per cycle.
// Leading zero digits are then dropped at one per cycle, and characters go
// out at one per cycle when the receiver does not stall. The next number is
// accepted while the last character still waits in the output register.
// A stalled receiver holds the output register and pauses the character
// sequencer. Reset empties the output register and returns to idle.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   char_code_o,
  output logic                         last_o
);

  // Decimal digits of 2^VALUE_BITS, which cover the largest magnitude, 2^(VALUE_BITS-1).
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * sidt_pkg::DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS);

  sidt_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic                  in_xfer;
  logic                  out_free;
  logic [VALUE_BITS-1:0] value_raw;
  logic [BCD_W-1:0]      bcd_step;
  logic [3:0]            top_digit;
  logic                  last_digit;

  assign value_raw  = value_i;
  assign in_stall_o = (state_q != sidt_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign top_digit  = bcd_q[BCD_W-1 -: sidt_pkg::DIGIT_W];
  assign last_digit = (dcnt_q == DCNT_W'(NUM_DIGITS - 1));

  sidt_dabble #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dabble (
    .bcd_i(bcd_q),
    .bit_i(mag_q[VALUE_BITS-1]),
    .bcd_o(bcd_step)
  );

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;

    unique case (state_q)
      sidt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          neg_d   = value_raw[VALUE_BITS-1];
          mag_d   = value_raw[VALUE_BITS-1] ? (~value_raw + 1'b1) : value_raw;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = sidt_pkg::ST_CONV;
        end
      end
      sidt_pkg::ST_CONV: begin
        bcd_d = bcd_step;
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          dcnt_d    = '0;
          started_d = 1'b0;
          state_d   = neg_q ? sidt_pkg::ST_SIGN : sidt_pkg::ST_DIGITS;
        end
      end
      sidt_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = sidt_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = sidt_pkg::ST_DIGITS;
        end
      end
      sidt_pkg::ST_DIGITS: begin
        // Leading zeros are dropped, but the units digit always goes out.
        if (!started_q && top_digit == 4'd0 && !last_digit) begin
          bcd_d  = {bcd_q[BCD_W-sidt_pkg::DIGIT_W-1:0], {sidt_pkg::DIGIT_W{1'b0}}};
          dcnt_d = dcnt_q + 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = sidt_pkg::CHAR_ZERO + {4'd0, top_digit};
          last_d      = last_digit;
          started_d   = 1'b1;
          bcd_d  = {bcd_q[BCD_W-sidt_pkg::DIGIT_W-1:0], {sidt_pkg::DIGIT_W{1'b0}}};
          dcnt_d = dcnt_q + 1'b1;
          if (last_digit) begin
            state_d = sidt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sidt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sidt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      started_q   <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      started_q   <= started_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // An accepted number always starts a fresh conversion pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == sidt_pkg::ST_CONV) && (cnt_q == '0))
    else $error("conversion did not start after an input transfer");

  // Any character that is not a digit must be a minus sign that is not last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (char_code_o < sidt_pkg::CHAR_ZERO || char_code_o > 8'd57))
      |-> (char_code_o == sidt_pkg::CHAR_MINUS) && !last_o)
    else $error("invalid character on the output");

  // A stalled character stays on the output until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
      |=> out_valid_o && $stable(char_code_o) && $stable(last_o))
    else $error("output changed while stalled");

endmodule
